### design/assert_macros.svh
// Assertion macros used by gcd_ctrl. Synthesis builds define SYNTH,
// which turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### design/gcd_pkg.sv
package gcd_pkg;

   typedef enum logic {
      GCD_IDLE,
      GCD_RUN
   } gcd_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic store;
   } gcd_cmd_type;

   typedef struct packed {
      logic done;
   } gcd_status_type;

endpackage

### design/gcd_unit.sv
// Greatest common divisor of two unsigned WIDTH-bit operands.
// The request channel carries one word of two operands, req_a_value and
// req_b_value, taken at a clock edge with req_valid high and req_stall low.
// The response channel returns one word, rsp_divisor, for each request,
// in order; it is taken when rsp_valid is high and rsp_stall is low.
// If one operand is zero the divisor is the other one, so two zeros give zero.
// The datapath runs binary gcd, one halving or subtract-and-halve step per
// cycle through a single WIDTH-bit compare and subtract. A word is loaded,
// stepped until one operand is zero, and then its result is registered;
// small operands or operands that share low zero bits take fewer steps.
// One request is worked on at a time; req_stall is high while it runs.
// The result sits in an output register, so a new request is accepted while
// the previous divisor still waits on a stalled response channel. If the
// receiver is still stalling when the next result is ready, the unit holds it
// and keeps req_stall high until the output register frees up.
// Synchronous reset returns the unit to idle with no response pending.
module gcd_unit #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_a_value,
   input  logic [WIDTH-1:0] req_b_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_divisor
);
   import gcd_pkg::*;

   gcd_cmd_type    cmd;
   gcd_status_type status;

   gcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gcd_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .rsp_divisor (rsp_divisor)
   );

endmodule

### design/gcd_dpath.sv
module gcd_dpath #(
   parameter int WIDTH = 64
) (
   input  logic                    clock,
   input  gcd_pkg::gcd_cmd_type    cmd,
   output gcd_pkg::gcd_status_type status,
   input  logic [WIDTH-1:0]        req_a_value,
   input  logic [WIDTH-1:0]        req_b_value,
   output logic [WIDTH-1:0]        rsp_divisor
);
   import gcd_pkg::*;

   localparam int KW = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [WIDTH-1:0] divisor_ff, divisor_in;
   logic [WIDTH-1:0] big, little, diff;
   logic             a_ge_b;

   // Binary gcd: strip common factors of two into k, strip lone factors of
   // two, and replace the larger odd operand by half the difference.
   always_comb begin
      a_ge_b = a_ff >= b_ff;
      big    = a_ge_b ? a_ff : b_ff;
      little = a_ge_b ? b_ff : a_ff;
      diff   = big - little;

      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      divisor_in = divisor_ff;

      if (cmd.load) begin
         a_in = req_a_value;
         b_in = req_b_value;
         k_in = '0;
      end else if (cmd.step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ge_b) begin
            a_in = diff >> 1;
         end else begin
            b_in = diff >> 1;
         end
      end

      if (cmd.store) begin
         divisor_in = (a_ff | b_ff) << k_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      divisor_ff <= divisor_in;
   end

   assign status.done = (a_ff == '0) || (b_ff == '0);
   assign rsp_divisor = divisor_ff;

endmodule

### design/gcd_ctrl.sv
`include "assert_macros.svh"

module gcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  gcd_pkg::gcd_status_type status,
   output gcd_pkg::gcd_cmd_type    cmd
);
   import gcd_pkg::*;

   gcd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GCD_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         GCD_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = GCD_RUN;
            end
         end
         GCD_RUN: begin
            if (!status.done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.store    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = GCD_IDLE;
            end
         end
         default: begin
            state_in = GCD_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_SAME(a_store_when_done, clock, reset, cmd.store, status.done)
   `ASSERT_SAME(a_store_needs_room, clock, reset, cmd.store, !(rsp_valid_ff && rsp_stall))
   `ASSERT_NEXT(a_accept_starts_run, clock, reset, req_valid && !req_stall,
                state_ff == GCD_RUN)
   `ASSERT_NEXT(a_store_shows_word, clock, reset, cmd.store, rsp_valid_ff)

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 2 * WIDTH + 12;
   localparam int REPORT_LIMIT = 10;

   localparam logic [1:0] STALL_NONE = 2'd0;
   localparam logic [1:0] STALL_LIGHT = 2'd1;
   localparam logic [1:0] STALL_HEAVY = 2'd2;
   localparam logic [1:0] STALL_PERIODIC = 2'd3;

   localparam logic [WIDTH-1:0] ALL_ONES = '1;
   localparam logic [WIDTH-1:0] FIB_93 = 64'd12200160415121876738;
   localparam logic [WIDTH-1:0] FIB_92 = 64'd7540113804746346429;

   typedef struct {
      logic [WIDTH-1:0] a_value;
      logic [WIDTH-1:0] b_value;
      logic [WIDTH-1:0] divisor;
   } gcd_case_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WIDTH-1:0] req_a_value = '0;
   logic [WIDTH-1:0] req_b_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [WIDTH-1:0] rsp_divisor;

   gcd_case_type pending_divisors[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 1;
   int unsigned  stall_phase_left = 0;
   logic [1:0]   stall_mode = STALL_NONE;

   gcd_unit #(
      .WIDTH(WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_a_value(req_a_value),
      .req_b_value(req_b_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_divisor(rsp_divisor)
   );

   always #4 clock = ~clock;

   function automatic logic [WIDTH-1:0] euclid_divisor(input logic [WIDTH-1:0] x,
                                                       input logic [WIDTH-1:0] y);
      logic [WIDTH-1:0] rem;
      while (y != '0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      return x;
   endfunction

   function automatic logic [WIDTH-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_phase_left <= $urandom_range(50, 400);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ((cycle_count % 37) < 20);
         end
      endcase
   end

   always @(posedge clock) begin
      gcd_case_type expected;
      gcd_case_type accepted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_divisors.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected response word: divisor %h", rsp_divisor);
            end else begin
               expected = pending_divisors.pop_front();
               if (rsp_divisor !== expected.divisor) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("divisor mismatch for a=%h b=%h: expected %h, actual %h",
                              expected.a_value, expected.b_value, expected.divisor,
                              rsp_divisor);
               end
            end
         end
         if (req_valid && !req_stall) begin
            accepted.a_value = req_a_value;
            accepted.b_value = req_b_value;
            accepted.divisor = euclid_divisor(req_a_value, req_b_value);
            pending_divisors.push_back(accepted);
         end
      end
   end

   task automatic send_operands(input logic [WIDTH-1:0] a_value,
                                input logic [WIDTH-1:0] b_value);
      int unsigned gap;
      req_valid <= 1'b1;
      req_a_value <= a_value;
      req_b_value <= b_value;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * WIDTH + 30)
                                           : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_divisors.size() != 0) @(posedge clock);
   endtask

   task automatic run_operand_extremes();
      send_operands('0, '0);
      send_operands('0, ALL_ONES);
      send_operands(ALL_ONES, '0);
      send_operands('0, 64'd12345);
      send_operands(64'd1, '0);
      send_operands(ALL_ONES, ALL_ONES);
      send_operands(64'd1, ALL_ONES);
      send_operands(ALL_ONES, 64'd1);
      send_operands(ALL_ONES, ALL_ONES - 1);
      send_operands(64'd1, 64'd1);
      send_operands(64'd7, 64'd7);
      send_operands(64'd12, 64'd18);
      send_operands(64'd18, 64'd12);
      send_operands(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
      send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_operands(64'h8000_0000_0000_0000, 64'd3);
      send_operands(ALL_ONES, 64'd3);
      send_operands(FIB_93, FIB_92);
      send_operands(FIB_92, FIB_93);
      send_operands(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFAD);
      send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_operands(64'h0000_0001_0000_0000, 64'h0000_0000_0001_0000);
      wait_for_results();
   endtask

   task automatic run_full_width_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_operands(random_word(), random_word());
   endtask

   task automatic run_shared_factor_random(input int unsigned count);
      int unsigned      factor_bits;
      logic [WIDTH-1:0] factor;
      logic [WIDTH-1:0] a_part;
      logic [WIDTH-1:0] b_part;
      for (int unsigned i = 0; i < count; i++) begin
         factor_bits = $urandom_range(1, 40);
         factor = random_word() >> (WIDTH - factor_bits);
         a_part = random_word() >> factor_bits;
         b_part = random_word() >> factor_bits;
         if ($urandom_range(0, 15) == 0)
            b_part = '0;
         send_operands(factor * a_part, factor * b_part);
         if (i == count / 2)
            wait_for_results();
      end
   endtask

   task automatic run_mixed_width_random(input int unsigned count);
      int unsigned      a_bits;
      int unsigned      b_bits;
      int unsigned      shift;
      logic [WIDTH-1:0] a_value;
      logic [WIDTH-1:0] b_value;
      for (int unsigned i = 0; i < count; i++) begin
         a_bits = $urandom_range(1, WIDTH);
         b_bits = $urandom_range(1, WIDTH);
         a_value = random_word() >> (WIDTH - a_bits);
         b_value = random_word() >> (WIDTH - b_bits);
         if ($urandom_range(0, 3) == 0) begin
            shift = $urandom_range(1, 20);
            a_value = a_value << shift;
            b_value = b_value << shift;
         end
         if ($urandom_range(0, 19) == 0)
            a_value = '0;
         send_operands(a_value, b_value);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_operand_extremes();
      run_full_width_random(380);
      run_shared_factor_random(400);
      run_mixed_width_random(350);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_divisors.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
